// ----- src/btff_pkg.sv -----
// shared command codes, status struct and constants for the heap allocator
package btff_pkg;

  // width of an extended byte offset: a block offset plus two 32-bit sizes
  localparam int XW = 34;

  // datapath commands issued by the controller
  typedef logic [4:0] cmd_t;
  localparam cmd_t CMD_NONE     = 5'd0;
  localparam cmd_t CMD_LOAD     = 5'd1;
  localparam cmd_t CMD_RD_BLK   = 5'd2;
  localparam cmd_t CMD_TAG      = 5'd3;
  localparam cmd_t CMD_LATCH    = 5'd4;
  localparam cmd_t CMD_HDR_SET  = 5'd5;
  localparam cmd_t CMD_HDR_CLR  = 5'd6;
  localparam cmd_t CMD_RD_FTR   = 5'd7;
  localparam cmd_t CMD_FTR_SET  = 5'd8;
  localparam cmd_t CMD_FTR_CLR  = 5'd9;
  localparam cmd_t CMD_OOM      = 5'd10;
  localparam cmd_t CMD_EXT_HDR  = 5'd11;
  localparam cmd_t CMD_EXT_FTR  = 5'd12;
  localparam cmd_t CMD_RD_PREV  = 5'd13;
  localparam cmd_t CMD_PREV     = 5'd14;
  localparam cmd_t CMD_RD_NEXT  = 5'd15;
  localparam cmd_t CMD_NEXT     = 5'd16;
  localparam cmd_t CMD_MRG1     = 5'd17;
  localparam cmd_t CMD_MRG2     = 5'd18;

  // operation codes of an input item
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // status flags from datapath to controller
  typedef struct packed {
    logic blk_lt_brk;  // walk pointer below the break
    logic sz_zero;     // tag just read has size zero
    logic fit;         // tag just read is free and large enough
    logic sum_lt;      // next block offset still below the break
    logic oom;         // break extension would overrun the store
    logic free_bad;    // free header offset misaligned or at or past the break
    logic merge;       // a neighbour coalesces with the freed block
  } stat_t;

endpackage

// ----- src/btff_datapath.sv -----
// heap datapath: tag store, walk pointer, break, tag arithmetic and result register
module btff_datapath import btff_pkg::*; #(
  parameter int HEAP_WORDS = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output stat_t       stat,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  logic [11:0] request_bytes,
  input  logic [31:0] payload_address,
  output logic [31:0] result_address,
  output logic        status
);

  localparam int AW = $clog2(HEAP_WORDS);
  localparam int OW = AW + 3;
  localparam logic [XW-1:0] LIMIT = XW'(HEAP_WORDS) << 2;

  logic [31:0]   mem [HEAP_WORDS];
  logic [31:0]   q;
  logic          rd_ok;
  logic [31:0]   base;
  logic [OW-1:0] brk;
  logic [OW-1:0] blk;
  logic [12:0]   need;
  logic [31:0]   h;
  logic [31:0]   treg;
  logic [31:0]   ps;
  logic [31:0]   ns;
  logic          mp;
  logic          mn;

  logic [31:0]   rdata;
  logic [31:0]   rsz;
  logic [31:0]   sz;
  logic [XW-1:0] blk_x, brk_x, sz_x, need_x, ftr_x, nh_x, sum_x, off;
  logic [13:0]   need_sum;
  logic [31:0]   t;
  logic [31:0]   wdata;
  logic          we;
  logic          rd;
  logic          inrange;
  logic [AW-1:0] idx;

  // read data of an out-of-range tag is zero
  assign rdata = rd_ok ? q : 32'd0;
  assign rsz   = {rdata[31:3], 3'b000};
  assign sz    = {treg[31:3], 3'b000};

  // offset arithmetic
  assign blk_x  = XW'(blk);
  assign brk_x  = XW'(brk);
  assign sz_x   = XW'(sz);
  assign need_x = XW'(need);
  assign ftr_x  = blk_x + sz_x - XW'(4);
  assign nh_x   = blk_x + sz_x;
  assign sum_x  = blk_x + XW'(rsz);
  assign need_sum = 14'(request_bytes) + 14'd15;
  assign t = (sz + (mp ? ps : 32'd0) + (mn ? ns : 32'd0)) & ~32'd1;

  // status toward the controller
  assign stat.blk_lt_brk = blk < brk;
  assign stat.sz_zero    = rsz == 32'd0;
  assign stat.fit        = !rdata[0] && (rsz >= 32'(need));
  assign stat.sum_lt     = sum_x < brk_x;
  assign stat.oom        = (brk_x + need_x) > LIMIT;
  assign stat.free_bad   = (h[2:0] != 3'd0) || (h >= 32'(brk));
  assign stat.merge      = mp || mn;

  // tag address, write data and strobes per command
  always_comb begin
    off   = blk_x;
    wdata = treg;
    we    = 1'b0;
    rd    = 1'b0;
    unique case (cmd)
      CMD_RD_BLK:  rd = 1'b1;
      CMD_HDR_SET: begin
        we = 1'b1; wdata = treg | 32'd1;
      end
      CMD_HDR_CLR: begin
        we = 1'b1; wdata = treg & ~32'd1;
      end
      CMD_RD_FTR:  begin
        rd = 1'b1; off = ftr_x;
      end
      CMD_FTR_SET: begin
        we = 1'b1; off = ftr_x; wdata = rdata | 32'd1;
      end
      CMD_FTR_CLR: begin
        we = 1'b1; off = ftr_x; wdata = rdata & ~32'd1;
      end
      CMD_EXT_HDR: begin
        we = 1'b1; off = brk_x; wdata = 32'(need) | 32'd1;
      end
      CMD_EXT_FTR: begin
        we = 1'b1; off = brk_x + need_x - XW'(4); wdata = 32'(need) | 32'd1;
      end
      CMD_RD_PREV: begin
        rd = 1'b1; off = blk_x - XW'(4);
      end
      CMD_RD_NEXT: begin
        rd = 1'b1; off = nh_x;
      end
      CMD_MRG1:    begin
        we = 1'b1; off = mp ? blk_x - XW'(ps) : blk_x; wdata = t;
      end
      CMD_MRG2:    begin
        we = 1'b1; off = mn ? nh_x + XW'(ns) - XW'(4) : ftr_x; wdata = t;
      end
      default: ;
    endcase
  end

  assign inrange = off[XW-1:2] < (XW-2)'(HEAP_WORDS);
  assign idx     = off[AW+1:2];

  // tag store, one port, registered read
  always_ff @(posedge clk) begin
    if (we && inrange) begin
      mem[idx] <= wdata;
    end
    if (rd) begin
      q <= mem[idx];
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      base  <= 32'd0;
      brk   <= '0;
      rd_ok <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        base <= cfg_wr_data;
      end
      if (rd) begin
        rd_ok <= inrange;
      end
      if (cmd == CMD_EXT_FTR) begin
        brk <= brk + OW'(need);
      end
    end
  end

  // item registers and walk state
  always_ff @(posedge clk) begin
    unique case (cmd)
      CMD_LOAD: begin
        need           <= {need_sum[12:3], 3'b000};
        h              <= payload_address - base - 32'd4;
        blk            <= '0;
        result_address <= payload_address;
        status         <= 1'b0;
        mp             <= 1'b0;
        mn             <= 1'b0;
      end
      CMD_TAG: begin
        treg <= rdata;
        if (!stat.fit) begin
          blk <= sum_x[OW-1:0];
        end
      end
      // free works at the header offset
      CMD_LATCH: begin
        treg <= rdata;
        blk  <= h[OW-1:0];
      end
      CMD_FTR_SET: begin
        result_address <= base + 32'(blk) + 32'd4;
        status         <= 1'b0;
      end
      CMD_OOM: begin
        result_address <= 32'd0;
        status         <= 1'b1;
      end
      CMD_EXT_HDR: begin
        result_address <= base + 32'(brk) + 32'd4;
        status         <= 1'b0;
      end
      CMD_PREV: begin
        ps <= rsz;
        mp <= (blk != '0) && !rdata[0] && (rsz != 32'd0) && (rsz <= 32'(blk));
      end
      CMD_NEXT: begin
        ns <= rsz;
        mn <= (nh_x < brk_x) && !rdata[0];
      end
      default: ;
    endcase
  end

endmodule

// ----- src/btff_ctrl.sv -----
// allocator controller state machine
module btff_ctrl import btff_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  logic  operation,
  output logic  out_valid,
  input  logic  out_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_A_RD  = 5'd1;
  localparam logic [4:0] S_A_TAG = 5'd2;
  localparam logic [4:0] S_A_HDR = 5'd3;
  localparam logic [4:0] S_A_RDF = 5'd4;
  localparam logic [4:0] S_A_FTR = 5'd5;
  localparam logic [4:0] S_A_EXT = 5'd6;
  localparam logic [4:0] S_A_EX2 = 5'd7;
  localparam logic [4:0] S_F_CHK = 5'd8;
  localparam logic [4:0] S_F_HT  = 5'd9;
  localparam logic [4:0] S_F_WH  = 5'd10;
  localparam logic [4:0] S_F_RF  = 5'd11;
  localparam logic [4:0] S_F_WF  = 5'd12;
  localparam logic [4:0] S_F_RP  = 5'd13;
  localparam logic [4:0] S_F_P   = 5'd14;
  localparam logic [4:0] S_F_RN  = 5'd15;
  localparam logic [4:0] S_F_N   = 5'd16;
  localparam logic [4:0] S_F_M1  = 5'd17;
  localparam logic [4:0] S_F_M2  = 5'd18;
  localparam logic [4:0] S_DONE  = 5'd19;
  localparam logic [4:0] S_F_LD  = 5'd20;

  logic [4:0] state, state_next;

  assign in_ready  = state == S_IDLE;
  assign out_valid = state == S_DONE;

  // next state and command
  always_comb begin
    state_next = state;
    cmd        = CMD_NONE;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd        = CMD_LOAD;
          state_next = (operation == OP_FREE) ? S_F_LD : S_A_RD;
        end
      end
      S_A_RD: begin
        if (stat.blk_lt_brk) begin
          cmd = CMD_RD_BLK; state_next = S_A_TAG;
        end else begin
          state_next = S_A_EXT;
        end
      end
      S_A_TAG: begin
        cmd = CMD_TAG;
        priority if (stat.sz_zero) state_next = S_A_EXT;
        else if (stat.fit)         state_next = S_A_HDR;
        else if (stat.sum_lt)      state_next = S_A_RD;
        else                       state_next = S_A_EXT;
      end
      S_A_HDR: begin
        cmd = CMD_HDR_SET; state_next = S_A_RDF;
      end
      S_A_RDF: begin
        cmd = CMD_RD_FTR; state_next = S_A_FTR;
      end
      S_A_FTR: begin
        cmd = CMD_FTR_SET; state_next = S_DONE;
      end
      S_A_EXT: begin
        if (stat.oom) begin
          cmd = CMD_OOM; state_next = S_DONE;
        end else begin
          cmd = CMD_EXT_HDR; state_next = S_A_EX2;
        end
      end
      S_A_EX2: begin
        cmd = CMD_EXT_FTR; state_next = S_DONE;
      end
      S_F_LD: begin
        cmd = CMD_LATCH; state_next = S_F_CHK;
      end
      S_F_CHK: begin
        if (stat.free_bad) begin
          state_next = S_DONE;
        end else begin
          cmd = CMD_RD_BLK; state_next = S_F_HT;
        end
      end
      S_F_HT: begin
        cmd        = CMD_LATCH;
        state_next = stat.sz_zero ? S_DONE : S_F_WH;
      end
      S_F_WH: begin
        cmd = CMD_HDR_CLR; state_next = S_F_RF;
      end
      S_F_RF: begin
        cmd = CMD_RD_FTR; state_next = S_F_WF;
      end
      S_F_WF: begin
        cmd = CMD_FTR_CLR; state_next = S_F_RP;
      end
      S_F_RP: begin
        cmd = CMD_RD_PREV; state_next = S_F_P;
      end
      S_F_P: begin
        cmd = CMD_PREV; state_next = S_F_RN;
      end
      S_F_RN: begin
        cmd = CMD_RD_NEXT; state_next = S_F_N;
      end
      S_F_N: begin
        cmd = CMD_NEXT; state_next = S_F_M1;
      end
      S_F_M1: begin
        if (stat.merge) begin
          cmd = CMD_MRG1; state_next = S_F_M2;
        end else begin
          state_next = S_DONE;
        end
      end
      S_F_M2: begin
        cmd = CMD_MRG2; state_next = S_DONE;
      end
      S_DONE: begin
        if (out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // never take an item while a result is shown
  assert property (@(posedge clk) disable iff (rst) !(in_ready && out_valid))
    else $error("input and output handshakes open together");

  // an accepted item leaves idle
  assert property (@(posedge clk) disable iff (rst) in_valid && in_ready |=> !in_ready)
    else $error("item accepted but controller stayed idle");

  // a delivered result returns the block to idle
  assert property (@(posedge clk) disable iff (rst) out_valid && out_ready |=> in_ready)
    else $error("result delivered but controller not idle");

endmodule

// ----- src/boundary_tag_first_fit_allocator.sv -----
// Boundary-tag first-fit heap allocator: top level.
// One item at a time. Allocate walks the blocks, reading each tag, then marks a fit,
// extends the break or flags out of memory; free checks, clears tags and coalesces.
// The result then holds until taken; the next item can be taken in the cycle after that.
// Rate is set by the single-port tag store, one tag access per cycle.
// Reset (rst, synchronous) clears the break and base address, not the tag store.
module boundary_tag_first_fit_allocator import btff_pkg::*; #(
  parameter int HEAP_WORDS = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        operation,
  input  logic [11:0] request_bytes,
  input  logic [31:0] payload_address,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] result_address,
  output logic        status
);

  cmd_t  cmd;
  stat_t stat;

  // sequencing
  btff_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .operation (operation),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // tag store and arithmetic
  btff_datapath #(.HEAP_WORDS(HEAP_WORDS)) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .request_bytes   (request_bytes),
    .payload_address (payload_address),
    .result_address  (result_address),
    .status          (status)
  );

endmodule

// ----- tb/boundary_tag_first_fit_allocator_tb.sv -----
// testbench for the boundary-tag first-fit heap allocator, with its own heap predictor
`timescale 1ns / 1ps

module boundary_tag_first_fit_allocator_tb import btff_pkg::*;;

  localparam int STORE_WORDS = 1024;
  localparam int SW = $clog2(STORE_WORDS);
  localparam int STALL_LIMIT = 5000;
  localparam int HOLD_CYCLES = 400;

  typedef struct {
    logic [31:0] addr;
    logic        st;
  } heap_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [31:0] cfg_wr_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        operation = OP_ALLOC;
  logic [11:0] request_bytes = '0;
  logic [31:0] payload_address = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] result_address;
  logic        status;

  // predictor state
  logic [31:0] tag_store [STORE_WORDS];
  logic [31:0] brk;
  logic [31:0] heap_base;
  logic [31:0] live_offs [$];
  heap_result_t granted_q [$];

  int mismatches = 0;
  int n_sent = 0, n_checked = 0, n_oom = 0, n_frees = 0, n_merges = 0;
  int burst_left = 0;
  bit no_gaps = 1'b0;
  bit hold_req = 1'b0;

  boundary_tag_first_fit_allocator #(.HEAP_WORDS(STORE_WORDS)) u_top (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .operation(operation), .request_bytes(request_bytes),
    .payload_address(payload_address),
    .out_valid(out_valid), .out_ready(out_ready),
    .result_address(result_address), .status(status)
  );

  // clock
  initial begin
    forever #6 clk = ~clk;
  end

  // tag store access, out of range reads give zero and writes are dropped
  function automatic logic [31:0] tag_rd(input logic [63:0] off);
    if ((off >> 2) >= STORE_WORDS) return '0;
    return tag_store[off[SW+1:2]];
  endfunction

  function automatic void tag_wr(input logic [63:0] off, input logic [31:0] v);
    if ((off >> 2) < STORE_WORDS) tag_store[off[SW+1:2]] = v;
  endfunction

  // first-fit allocate: walk the blocks, else extend the break
  function automatic heap_result_t predict_alloc(input logic [11:0] req);
    heap_result_t r;
    logic [63:0] need, p, sz;
    logic [31:0] tg;
    need = (64'(req) + 64'd15) & ~64'd7;
    p = '0;
    while (p < 64'(brk)) begin
      tg = tag_rd(p);
      sz = 64'(tg & ~32'd7);
      if (sz == 0) break;
      if (!tg[0] && sz >= need) begin
        tag_wr(p, tg | 32'd1);
        tag_wr(p + sz - 4, tag_rd(p + sz - 4) | 32'd1);
        r.addr = heap_base + p[31:0] + 32'd4;
        r.st = 1'b0;
        live_offs.push_back(p[31:0]);
        return r;
      end
      p += sz;
    end
    if (64'(brk) + need > 64'(STORE_WORDS * 4)) begin
      r.addr = '0;
      r.st = 1'b1;
      n_oom++;
      return r;
    end
    p = 64'(brk);
    tag_wr(p, need[31:0] | 32'd1);
    tag_wr(p + need - 4, need[31:0] | 32'd1);
    brk = p[31:0] + need[31:0];
    r.addr = heap_base + p[31:0] + 32'd4;
    r.st = 1'b0;
    live_offs.push_back(p[31:0]);
    return r;
  endfunction

  // free: clear the tags and coalesce with free neighbours
  function automatic void predict_free(input logic [31:0] addr);
    logic [31:0] h, sz, ps, ns, pf, nt, t;
    logic [63:0] ftr, nh;
    bit mp, mn;
    h = addr - heap_base - 32'd4;
    ps = '0; ns = '0; mp = 1'b0; mn = 1'b0;
    if (h[2:0] != 0 || h >= brk) return;
    sz = tag_rd(64'(h)) & ~32'd7;
    if (sz == 0) return;
    ftr = 64'(h) + 64'(sz) - 4;
    tag_wr(64'(h), tag_rd(64'(h)) & ~32'd1);
    tag_wr(ftr, tag_rd(ftr) & ~32'd1);
    if (h != 0) begin
      pf = tag_rd(64'(h) - 4);
      ps = pf & ~32'd7;
      if (!pf[0] && ps != 0 && ps <= h) mp = 1'b1;
    end
    nh = 64'(h) + 64'(sz);
    if (nh < 64'(brk)) begin
      nt = tag_rd(nh);
      if (!nt[0]) begin
        mn = 1'b1;
        ns = nt & ~32'd7;
      end
    end
    if (mp || mn) n_merges++;
    if (mp && !mn) begin
      t = (sz + ps) & ~32'd1;
      tag_wr(64'(h - ps), t);
      tag_wr(ftr, t);
    end else if (!mp && mn) begin
      t = (sz + ns) & ~32'd1;
      tag_wr(64'(h), t);
      tag_wr(nh + 64'(ns) - 4, t);
    end else if (mp && mn) begin
      t = (sz + ps + ns) & ~32'd1;
      tag_wr(64'(h - ps), t);
      tag_wr(nh + 64'(ns) - 4, t);
    end
  endfunction

  // send one item in bursts with gaps, predict at acceptance
  task automatic send_item(input logic op, input logic [11:0] req, input logic [31:0] addr);
    heap_result_t r;
    if (!no_gaps && burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
      burst_left = $urandom_range(1, 30);
    end
    if (burst_left > 0) burst_left--;
    in_valid <= 1'b1;
    operation <= op;
    request_bytes <= req;
    payload_address <= addr;
    forever begin
      @(negedge clk);
      if (in_ready) break;
    end
    @(posedge clk);
    n_sent++;
    if (op == OP_ALLOC) begin
      r = predict_alloc(req);
    end else begin
      predict_free(addr);
      r.addr = addr;
      r.st = 1'b0;
      n_frees++;
    end
    granted_q.push_back(r);
  endtask

  // free the live block at a given list position
  task automatic free_live(input int idx);
    logic [31:0] off;
    off = live_offs[idx];
    live_offs.delete(idx);
    send_item(OP_FREE, 12'($urandom), heap_base + off + 32'd4);
  endtask

  task automatic alloc_bytes(input logic [11:0] req);
    send_item(OP_ALLOC, req, $urandom);
  endtask

  // wait for the block to go idle, then write the base register
  task automatic write_base(input logic [31:0] b);
    in_valid <= 1'b0;
    @(posedge clk);
    while (granted_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= b;
    @(posedge clk);
    heap_base = b;
    cfg_wr_en <= 1'b0;
  endtask

  // tag extremes, out of memory and every kind of coalescing
  task automatic test_directed;
    alloc_bytes(12'd0);
    alloc_bytes(12'd1);
    alloc_bytes(12'd7);
    alloc_bytes(12'd8);
    alloc_bytes(12'd4088);
    alloc_bytes(12'd100);
    alloc_bytes(12'd200);
    alloc_bytes(12'd16);
    // live order: 0,1,7,8,100,200,16 requested bytes (4088 runs out of memory)
    free_live(1);                       // no free neighbour
    free_live(1);                       // merges backward
    free_live(2);                       // no free neighbour
    free_live(1);                       // merges both sides
    free_live(0);                       // first block, merges forward
    alloc_bytes(12'd20);                // reuses the merged block whole
    alloc_bytes(12'd4000);              // out of memory
    alloc_bytes(12'hFFF);
  endtask

  // frees the block rejects: misaligned or at or past the break
  task automatic test_bad_free;
    send_item(OP_FREE, 12'hFFF, heap_base + 32'd1);
    send_item(OP_FREE, 12'h000, heap_base + brk + 32'd4);
    send_item(OP_FREE, 12'h5A5, 32'hFFFF_FFFF);
    send_item(OP_FREE, 12'h0F0, heap_base + 32'd6);
    send_item(OP_FREE, 12'h000, heap_base + 32'h1000_0004);
  endtask

  // one random request: mostly well-formed allocate and free, some bad frees
  task automatic random_item;
    int k;
    logic [11:0] req;
    k = $urandom_range(0, 99);
    if (k < 45 || live_offs.size() == 0) begin
      k = $urandom_range(0, 99);
      if (k < 70) req = 12'($urandom_range(0, 120));
      else if (k < 95) req = 12'($urandom_range(0, 600));
      else req = 12'($urandom_range(0, 4088));
      alloc_bytes(req);
    end else if (k < 94) begin
      free_live($urandom_range(0, live_offs.size() - 1));
    end else begin
      if ($urandom_range(0, 1))
        send_item(OP_FREE, 12'($urandom), heap_base + (brk & ~32'd7) + 32'd4
                  + 32'($urandom_range(0, 64)) * 8);
      else
        send_item(OP_FREE, 12'($urandom), heap_base + 32'($urandom_range(0, 511)) * 8
                  + 32'($urandom_range(1, 7)));
    end
  endtask

  task automatic test_random(input int n);
    repeat (n) random_item();
  endtask

  // receiver holds off while the sender keeps offering items
  task automatic test_backpressure;
    hold_req = 1'b1;
    no_gaps = 1'b1;
    repeat (25) random_item();
    no_gaps = 1'b0;
  endtask

  // receiver stall pattern, with a long hold-off on request
  initial begin : receiver
    int mode, cnt, hold_cnt;
    mode = 0; cnt = 0; hold_cnt = 0;
    forever begin
      @(posedge clk);
      if (hold_req && hold_cnt == 0) begin
        hold_cnt = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (cnt == 0) begin
        mode = $urandom_range(0, 3);
        cnt = $urandom_range(100, 600);
      end
      cnt--;
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_ready <= 1'b0;
      end else begin
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= ($urandom_range(0, 3) != 0);
          2: out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= (cnt % 7 < 4);
        endcase
      end
    end
  end

  // result checking, sampled on the falling edge before the accepting edge
  always @(negedge clk) begin : result_check
    heap_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (granted_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: addr=%h status=%b", result_address, status);
      end else begin
        want = granted_q.pop_front();
        n_checked++;
        if (result_address !== want.addr || status !== want.st) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected addr=%h status=%b, got addr=%h status=%b",
                     want.addr, want.st, result_address, status);
        end
      end
    end
  end

  // watchdog on cycles with no item moving on either side
  initial begin : watchdog
    int idle;
    idle = 0;
    forever begin
      @(negedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle = 0;
      else idle++;
      if (idle >= STALL_LIMIT) begin
        $display("timeout: no item moved for %0d cycles", idle);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // test sequence
  initial begin : main
    int waited;
    for (int i = 0; i < STORE_WORDS; i++) tag_store[i] = '0;
    brk = '0;
    heap_base = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_bad_free();
    write_base(32'hFFFF_FFF8);
    test_directed();
    test_bad_free();
    test_random(270);
    test_backpressure();
    write_base({29'($urandom_range(0, 32'h1FFF_FFFF)), 3'b000});
    no_gaps = 1'b1;
    test_random(270);
    no_gaps = 1'b0;
    write_base(32'd8);
    test_random(270);
    write_base(32'h8000_0000);
    test_random(270);
    write_base(32'h0000_0000);
    test_random(270);
    in_valid <= 1'b0;
    waited = 0;
    while (granted_q.size() != 0 && waited < 20 * STALL_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (50) @(posedge clk);
    if (granted_q.size() != 0) mismatches++;
    $display("sent %0d items, checked %0d results: %0d out of memory, %0d frees, %0d merges",
             n_sent, n_checked, n_oom, n_frees, n_merges);
    $display("covered five base settings, bad frees, long output hold-off; %0d mismatches",
             mismatches);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
